>>> rtl/vnorm_pkg.sv
package vnorm_pkg;

	localparam int IN_WIDTH   = 16;
	localparam int FRAC_BITS  = 15;
	localparam int UNIT_WIDTH = FRAC_BITS + 1;
	localparam int MAG_WIDTH  = IN_WIDTH;
	localparam int SUM_WIDTH  = 2 * IN_WIDTH + 2;
	// root bits produced, one per sqrt cell
	localparam int ROOT_BITS  = SUM_WIDTH / 2;
	localparam int NUM_W      = MAG_WIDTH + FRAC_BITS;
	// remainder needs one bit over the divisor
	localparam int REM_WIDTH  = ROOT_BITS + 1;
	localparam int QUO_WIDTH  = NUM_W;
	localparam logic [QUO_WIDTH-1:0] UNIT_MAX = QUO_WIDTH'((64'd1 << FRAC_BITS) - 64'd1);

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] comp_x;
		logic signed [IN_WIDTH-1:0] comp_y;
		logic signed [IN_WIDTH-1:0] comp_z;
	} vnorm_req_t;

	typedef struct packed {
		logic        [IN_WIDTH-1:0]   length;
		logic signed [UNIT_WIDTH-1:0] unit_x;
		logic signed [UNIT_WIDTH-1:0] unit_y;
		logic signed [UNIT_WIDTH-1:0] unit_z;
		logic                         is_zero;
	} vnorm_res_t;

	// magnitudes and signs carried alongside the arithmetic
	typedef struct packed {
		logic                 valid;
		logic [MAG_WIDTH-1:0] mx;
		logic [MAG_WIDTH-1:0] my;
		logic [MAG_WIDTH-1:0] mz;
		logic                 nx;
		logic                 ny;
		logic                 nz;
	} vnorm_side_t;

endpackage

>>> rtl/vnorm_sqrt_cell.sv
module vnorm_sqrt_cell import vnorm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vnorm_side_t            side_in,
	input  logic [SUM_WIDTH-1:0]   rem_in,
	input  logic [ROOT_BITS-1:0]   root_in,
	input  logic [SUM_WIDTH-1:0]   rad_in,
	output vnorm_side_t            side_out,
	output logic [SUM_WIDTH-1:0]   rem_out,
	output logic [ROOT_BITS-1:0]   root_out,
	output logic [SUM_WIDTH-1:0]   rad_out
);

	// one restoring step: bring down two radicand bits, try root*4+1
	logic [SUM_WIDTH-1:0] rem_shift;
	logic [SUM_WIDTH-1:0] trial;
	logic                 take;

	assign rem_shift = {rem_in[SUM_WIDTH-3:0], rad_in[SUM_WIDTH-1:SUM_WIDTH-2]};
	assign trial     = SUM_WIDTH'({root_in[ROOT_BITS-2:0], 2'b01});
	assign take      = rem_shift >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_out <= '0;
		end else begin
			side_out <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_out     <= take ? rem_shift - trial : rem_shift;
		root_out    <= {root_in[ROOT_BITS-2:0], take};
		rad_out     <= {rad_in[SUM_WIDTH-3:0], 2'b00};
	end

endmodule

>>> rtl/vnorm_div_cell.sv
module vnorm_div_cell import vnorm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vnorm_side_t            side_in,
	input  logic [ROOT_BITS-1:0]   len_in,
	input  logic [REM_WIDTH-1:0]   rem_in [3],
	input  logic [QUO_WIDTH-1:0]   num_in [3],
	output vnorm_side_t            side_out,
	output logic [ROOT_BITS-1:0]   len_out,
	output logic [REM_WIDTH-1:0]   rem_out [3],
	output logic [QUO_WIDTH-1:0]   num_out [3]
);

	// one quotient bit for each of the three lanes; quotient shifts into num
	logic [REM_WIDTH-1:0] rs   [3];
	logic                 take [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rs[i]   = {rem_in[i][REM_WIDTH-2:0], num_in[i][QUO_WIDTH-1]};
			take[i] = rs[i] >= {1'b0, len_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_out <= '0;
		end else begin
			side_out <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		len_out     <= len_in;
		for (int i = 0; i < 3; i++) begin
			rem_out[i] <= take[i] ? rs[i] - {1'b0, len_in} : rs[i];
			num_out[i] <= {num_in[i][QUO_WIDTH-2:0], take[i]};
		end
	end

endmodule

>>> rtl/vector3_normalize_unit.sv
// a request passes stages 1 and 2, the sqrt cells, the divider cells and the result register
// throughput: one request per cycle; busy is never raised
// the depth is one sqrt cell per root bit plus one divider cell per quotient bit
// arst_n clears the valid chain and the carried side data; the result strobe is low after reset
module vector3_normalize_unit import vnorm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  vnorm_req_t request,
	output logic       done,
	output vnorm_res_t result
);

	assign busy = 1'b0;

	// stage 1: magnitudes
	vnorm_side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.valid <= start;
			side_s1.nx <= request.comp_x[IN_WIDTH-1];
			side_s1.ny <= request.comp_y[IN_WIDTH-1];
			side_s1.nz <= request.comp_z[IN_WIDTH-1];
			side_s1.mx <= request.comp_x[IN_WIDTH-1] ? MAG_WIDTH'(-request.comp_x) : request.comp_x;
			side_s1.my <= request.comp_y[IN_WIDTH-1] ? MAG_WIDTH'(-request.comp_y) : request.comp_y;
			side_s1.mz <= request.comp_z[IN_WIDTH-1] ? MAG_WIDTH'(-request.comp_z) : request.comp_z;
		end
	end

	// stage 2: sum of squares
	vnorm_side_t          side_s2;
	logic [SUM_WIDTH-1:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= SUM_WIDTH'(side_s1.mx * side_s1.mx) + SUM_WIDTH'(side_s1.my * side_s1.my)
			+ SUM_WIDTH'(side_s1.mz * side_s1.mz);
	end

	// square root chain
	vnorm_side_t          sq_side [ROOT_BITS+1];
	logic [SUM_WIDTH-1:0] sq_rem  [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] sq_root [ROOT_BITS+1];
	logic [SUM_WIDTH-1:0] sq_rad  [ROOT_BITS+1];

	assign sq_side[0] = side_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = sum_s2;

	for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
		vnorm_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.side_in  (sq_side[g]),
			.rem_in   (sq_rem[g]),
			.root_in  (sq_root[g]),
			.rad_in   (sq_rad[g]),
			.side_out (sq_side[g+1]),
			.rem_out  (sq_rem[g+1]),
			.root_out (sq_root[g+1]),
			.rad_out  (sq_rad[g+1])
		);
	end

	// divider chain, three lanes sharing the length
	vnorm_side_t          dv_side [NUM_W+1];
	logic [ROOT_BITS-1:0] dv_len  [NUM_W+1];
	logic [REM_WIDTH-1:0] dv_rem  [NUM_W+1][3];
	logic [QUO_WIDTH-1:0] dv_num  [NUM_W+1][3];

	assign dv_side[0]   = sq_side[ROOT_BITS];
	assign dv_len[0]    = sq_root[ROOT_BITS];
	assign dv_rem[0][0] = '0;
	assign dv_rem[0][1] = '0;
	assign dv_rem[0][2] = '0;
	assign dv_num[0][0] = {sq_side[ROOT_BITS].mx, FRAC_BITS'(0)};
	assign dv_num[0][1] = {sq_side[ROOT_BITS].my, FRAC_BITS'(0)};
	assign dv_num[0][2] = {sq_side[ROOT_BITS].mz, FRAC_BITS'(0)};

	for (genvar g = 0; g < NUM_W; g++) begin : g_div
		vnorm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.side_in  (dv_side[g]),
			.len_in   (dv_len[g]),
			.rem_in   (dv_rem[g]),
			.num_in   (dv_num[g]),
			.side_out (dv_side[g+1]),
			.len_out  (dv_len[g+1]),
			.rem_out  (dv_rem[g+1]),
			.num_out  (dv_num[g+1])
		);
	end

	// output stage: saturate, restore sign, zero vector
	vnorm_side_t          fin;
	logic [ROOT_BITS-1:0] fin_len;
	logic [QUO_WIDTH-1:0] qs [3];
	logic [UNIT_WIDTH-1:0] uq [3];
	logic                 zero;

	assign fin     = dv_side[NUM_W];
	assign fin_len = dv_len[NUM_W];
	assign zero    = fin_len == '0;

	always_comb begin
		qs[0] = dv_num[NUM_W][0];
		qs[1] = dv_num[NUM_W][1];
		qs[2] = dv_num[NUM_W][2];
		for (int i = 0; i < 3; i++) begin
			if (zero) begin
				qs[i] = '0;
			end else if (qs[i] > UNIT_MAX) begin
				qs[i] = UNIT_MAX;
			end
		end
		uq[0] = fin.nx ? UNIT_WIDTH'(-qs[0]) : UNIT_WIDTH'(qs[0]);
		uq[1] = fin.ny ? UNIT_WIDTH'(-qs[1]) : UNIT_WIDTH'(qs[1]);
		uq[2] = fin.nz ? UNIT_WIDTH'(-qs[2]) : UNIT_WIDTH'(qs[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		result.length  <= IN_WIDTH'(fin_len);
		result.unit_x  <= uq[0];
		result.unit_y  <= uq[1];
		result.unit_z  <= uq[2];
		result.is_zero <= zero;
	end

endmodule

>>> rtl/vnorm_checker.sv
module vnorm_checker import vnorm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input vnorm_res_t result
);

	localparam int LAT = 2 + ROOT_BITS + NUM_W + 1;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_zero |-> result.length == '0 && result.unit_x == '0
			&& result.unit_y == '0 && result.unit_z == '0)
		else $error("zero vector with nonzero outputs");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without request");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.is_zero |-> result.length != '0)
		else $error("nonzero vector with zero length");

endmodule

bind vector3_normalize_unit vnorm_checker u_vnorm_checker (.*);
